@@ rtl/lru_tag_store_top_assert.svh @@
// ----------------------------------------------------------------------------
// lru tag store assertion macros
// Shared property forms for the tag store modules, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_TAG_STORE_TOP_ASSERT_SVH
`define LRU_TAG_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define LTS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg
// Sizes, codes and shared types of the lru tag store.
// ----------------------------------------------------------------------------
package lts_pkg;

    // table geometry
    localparam int SLOTS       = 10;
    localparam int DRAIN_COUNT = 4;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int RANK_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int DRAIN_W     = (DRAIN_COUNT > 1) ? $clog2(DRAIN_COUNT) : 1;

    // operation codes
    localparam logic FUNC_SAVE  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // stored report body, tag id kept apart
    typedef struct packed {
        logic [31:0] receiver;
        logic [7:0]  battery;
        logic [7:0]  rssi;
        logic [31:0] seq_num;
        logic [7:0]  temperature;
    } payload_t;

    // outcome of one pass over the table
    typedef struct packed {
        logic              done;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [RANK_W-1:0] hit_rank;
        logic              free;
        logic [IDX_W-1:0]  free_idx;
        logic [IDX_W-1:0]  lru_idx;
        logic              head;
        logic [IDX_W-1:0]  head_idx;
        logic [31:0]       head_tag;
    } scan_res_t;

    // table update command
    typedef struct packed {
        logic              save_en;
        logic              drain_en;
        logic [IDX_W-1:0]  idx;
        logic              fresh;
        logic              hit;
        logic [RANK_W-1:0] hit_rank;
    } tbl_cmd_t;

endpackage

@@ rtl/lts_table.sv @@
// ----------------------------------------------------------------------------
// lts_table
// Slot storage: tag ids, recency ranks, report bodies and the fill count.
// Applies one save or drain update per cycle to all ranks in parallel.
// ----------------------------------------------------------------------------
module lts_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lts_pkg::IDX_W-1:0]   rd_idx,
    output logic [31:0]                 rd_tag,
    output logic [lts_pkg::RANK_W-1:0]  rd_rank,
    input  logic [lts_pkg::IDX_W-1:0]   pl_idx,
    output lts_pkg::payload_t           pl_data,
    output logic [lts_pkg::CNT_W-1:0]   count,
    input  lts_pkg::tbl_cmd_t           cmd,
    input  logic [31:0]                 wr_tag,
    input  lts_pkg::payload_t           wr_pl
);

    logic [31:0]                tag_reg  [lts_pkg::SLOTS];
    logic [lts_pkg::RANK_W-1:0] rank_reg [lts_pkg::SLOTS];
    lts_pkg::payload_t          pl_reg   [lts_pkg::SLOTS];
    logic [lts_pkg::CNT_W-1:0]  count_reg;
    logic [lts_pkg::CNT_W-1:0]  old_rank;

    // read ports
    assign rd_tag  = tag_reg[rd_idx];
    assign rd_rank = rank_reg[rd_idx];
    assign pl_data = pl_reg[pl_idx];
    assign count   = count_reg;

    // rank of the chosen slot before the save: new slots rank past the end
    always_comb
    begin
        if (cmd.hit)
        begin
            old_rank = lts_pkg::CNT_W'(cmd.hit_rank);
        end
        else if (cmd.fresh)
        begin
            old_rank = count_reg;
        end
        else
        begin
            old_rank = count_reg - lts_pkg::CNT_W'(1);
        end
    end

    // tags, ranks and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < lts_pkg::SLOTS; s++)
            begin
                tag_reg[s]  <= '0;
                rank_reg[s] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.save_en)
        begin
            for (int s = 0; s < lts_pkg::SLOTS; s++)
            begin
                if (cmd.idx == lts_pkg::IDX_W'(s))
                begin
                    tag_reg[s]  <= wr_tag;
                    rank_reg[s] <= '0;
                end
                else if ((tag_reg[s] != '0) &&
                         (lts_pkg::CNT_W'(rank_reg[s]) < old_rank))
                begin
                    rank_reg[s] <= rank_reg[s] + lts_pkg::RANK_W'(1);
                end
            end
            if (cmd.fresh)
            begin
                count_reg <= count_reg + lts_pkg::CNT_W'(1);
            end
        end
        else if (cmd.drain_en)
        begin
            for (int s = 0; s < lts_pkg::SLOTS; s++)
            begin
                if (cmd.idx == lts_pkg::IDX_W'(s))
                begin
                    tag_reg[s]  <= '0;
                    rank_reg[s] <= '0;
                end
                else if ((tag_reg[s] != '0) && (rank_reg[s] != '0))
                begin
                    rank_reg[s] <= rank_reg[s] - lts_pkg::RANK_W'(1);
                end
            end
            count_reg <= count_reg - lts_pkg::CNT_W'(1);
        end
    end

    // report bodies, only read back from occupied slots
    always_ff @(posedge clk)
    begin
        if (cmd.save_en)
        begin
            pl_reg[cmd.idx] <= wr_pl;
        end
    end

`include "lru_tag_store_top_assert.svh"

    `LTS_ASSERT_IMPL(a_drain_not_empty, cmd.drain_en, count_reg != '0, "drain on empty table")
    `LTS_ASSERT_IMPL(a_fresh_has_room, cmd.save_en && cmd.fresh, count_reg < lts_pkg::CNT_W'(lts_pkg::SLOTS), "free slot taken in full table")
    `LTS_ASSERT_IMPL(a_evict_when_full, cmd.save_en && !cmd.fresh && !cmd.hit, count_reg == lts_pkg::CNT_W'(lts_pkg::SLOTS), "eviction with room left")

endmodule

@@ rtl/lts_scan.sv @@
// ----------------------------------------------------------------------------
// lts_scan
// Shared slot compare unit: walks the table one slot a cycle and records
// the matching slot, the first free slot, the least recent slot and the
// most recent slot.
// ----------------------------------------------------------------------------
module lts_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        drain_mode,
    input  logic [31:0]                 key,
    input  logic [lts_pkg::CNT_W-1:0]   count,
    input  logic [31:0]                 rd_tag,
    input  logic [lts_pkg::RANK_W-1:0]  rd_rank,
    output logic [lts_pkg::IDX_W-1:0]   idx,
    output lts_pkg::scan_res_t          res
);

    logic                        run_reg;
    logic                        done_reg;
    logic [lts_pkg::IDX_W-1:0]   idx_reg;
    logic                        hit_reg;
    logic [lts_pkg::IDX_W-1:0]   hit_idx_reg;
    logic [lts_pkg::RANK_W-1:0]  hit_rank_reg;
    logic                        free_reg;
    logic [lts_pkg::IDX_W-1:0]   free_idx_reg;
    logic                        lru_found_reg;
    logic [lts_pkg::IDX_W-1:0]   lru_idx_reg;
    logic                        head_reg;
    logic [lts_pkg::IDX_W-1:0]   head_idx_reg;
    logic [31:0]                 head_tag_reg;

    logic occ;
    logic is_hit;
    logic is_free;
    logic is_lru;
    logic is_head;
    logic last;

    // per-slot compares on the slot under the cursor
    always_comb
    begin
        occ     = (rd_tag != '0);
        is_hit  = !hit_reg && (rd_tag == key);
        is_free = !free_reg && !occ;
        is_lru  = !lru_found_reg &&
                  ((lts_pkg::CNT_W'(rd_rank) + lts_pkg::CNT_W'(1)) == count);
        is_head = !head_reg && occ && (rd_rank == '0);
        last    = (idx_reg == lts_pkg::IDX_W'(lts_pkg::SLOTS - 1));
    end

    // cursor and found slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            hit_rank_reg  <= '0;
            free_reg      <= 1'b0;
            free_idx_reg  <= '0;
            lru_found_reg <= 1'b0;
            lru_idx_reg   <= '0;
            head_reg      <= 1'b0;
            head_idx_reg  <= '0;
            head_tag_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg       <= 1'b1;
                idx_reg       <= '0;
                hit_reg       <= 1'b0;
                free_reg      <= 1'b0;
                lru_found_reg <= 1'b0;
                lru_idx_reg   <= '0;
                head_reg      <= 1'b0;
            end
            else if (run_reg)
            begin
                if (is_hit)
                begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= idx_reg;
                    hit_rank_reg <= rd_rank;
                end
                if (is_free)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
                if (is_lru)
                begin
                    lru_found_reg <= 1'b1;
                    lru_idx_reg   <= idx_reg;
                end
                if (is_head)
                begin
                    head_reg     <= 1'b1;
                    head_idx_reg <= idx_reg;
                    head_tag_reg <= rd_tag;
                end
                // a drain pass stops at the most recent slot
                if (last || (drain_mode && is_head))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + lts_pkg::IDX_W'(1);
                end
            end
        end
    end

    assign idx          = idx_reg;
    assign res.done     = done_reg;
    assign res.hit      = hit_reg;
    assign res.hit_idx  = hit_idx_reg;
    assign res.hit_rank = hit_rank_reg;
    assign res.free     = free_reg;
    assign res.free_idx = free_idx_reg;
    assign res.lru_idx  = lru_idx_reg;
    assign res.head     = head_reg;
    assign res.head_idx = head_idx_reg;
    assign res.head_tag = head_tag_reg;

endmodule

@@ rtl/lru_tag_store_top.sv @@
// ----------------------------------------------------------------------------
// lru_tag_store_top
// Recency-ordered table of tag reports with save and drain operations.
// ----------------------------------------------------------------------------
// A save word (func 0) updates the slot holding the same tag id, else the
// lowest free slot, else the least recent slot, and makes it most recent;
// a save with tag id zero is dropped. A drain word (func 1) returns
// DRAIN_COUNT result words, most recent first, freeing each drained slot,
// with zero filler (present low) once the table is empty; last_of_run marks
// the final one. One input word is taken at a time. Each save and each drain
// result is found by the single slot compare unit, which steps through the
// table one slot per cycle; a drain search ends at the most recent slot, and
// the output handshake follows it.
module lru_tag_store_top (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [31:0]        tag_id_in,
    input  logic [7:0]         battery_in,
    input  logic signed [7:0]  signal_in,
    input  logic [31:0]        sequence_in,
    input  logic signed [7:0]  temperature_in,
    // result words
    output logic               out_valid,
    input  logic               out_ready,
    output logic               present,
    output logic [31:0]        receiver_out,
    output logic [31:0]        tag_id_out,
    output logic [7:0]         battery_out,
    output logic signed [7:0]  signal_out,
    output logic [31:0]        sequence_out,
    output logic signed [7:0]  temperature_out,
    output logic               last_of_run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAVE_SCAN,
        ST_DRAIN_SCAN,
        ST_DRAIN_OUT
    } state_t;

    state_t                        state_reg,       state_next;
    logic [31:0]                   receiver_id_reg, receiver_id_next;
    logic [31:0]                   item_tag_reg,    item_tag_next;
    lts_pkg::payload_t             item_pl_reg,     item_pl_next;
    logic [lts_pkg::DRAIN_W-1:0]   drain_k_reg,     drain_k_next;
    logic                          out_valid_reg,   out_valid_next;
    logic                          present_reg,     present_next;
    logic                          last_reg,        last_next;
    logic [31:0]                   out_tag_reg,     out_tag_next;
    lts_pkg::payload_t             out_pl_reg,      out_pl_next;

    logic                          scan_start;
    logic [lts_pkg::IDX_W-1:0]     scan_idx;
    lts_pkg::scan_res_t            scan_res;
    logic [31:0]                   rd_tag;
    logic [lts_pkg::RANK_W-1:0]    rd_rank;
    lts_pkg::payload_t             pl_data;
    logic [lts_pkg::CNT_W-1:0]     count;
    lts_pkg::tbl_cmd_t             tbl_cmd;

    // slot storage
    lts_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (scan_idx),
        .rd_tag  (rd_tag),
        .rd_rank (rd_rank),
        .pl_idx  (scan_res.head_idx),
        .pl_data (pl_data),
        .count   (count),
        .cmd     (tbl_cmd),
        .wr_tag  (item_tag_reg),
        .wr_pl   (item_pl_reg)
    );

    // shared slot compare unit
    lts_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .drain_mode (state_reg == ST_DRAIN_SCAN),
        .key        (item_tag_reg),
        .count      (count),
        .rd_tag     (rd_tag),
        .rd_rank    (rd_rank),
        .idx        (scan_idx),
        .res        (scan_res)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        receiver_id_next = cfg_wr_en ? cfg_wr_data : receiver_id_reg;
        item_tag_next    = item_tag_reg;
        item_pl_next     = item_pl_reg;
        drain_k_next     = drain_k_reg;
        out_valid_next   = out_valid_reg;
        present_next     = present_reg;
        last_next        = last_reg;
        out_tag_next     = out_tag_reg;
        out_pl_next      = out_pl_reg;
        scan_start       = 1'b0;
        tbl_cmd          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_tag_next            = tag_id_in;
                    item_pl_next.receiver    = receiver_id_reg;
                    item_pl_next.battery     = battery_in;
                    item_pl_next.rssi        = $unsigned(signal_in);
                    item_pl_next.seq_num     = sequence_in;
                    item_pl_next.temperature = $unsigned(temperature_in);
                    if (func == lts_pkg::FUNC_DRAIN)
                    begin
                        drain_k_next = '0;
                        scan_start   = 1'b1;
                        state_next   = ST_DRAIN_SCAN;
                    end
                    else if (tag_id_in != '0)
                    begin
                        scan_start = 1'b1;
                        state_next = ST_SAVE_SCAN;
                    end
                end
            end

            ST_SAVE_SCAN:
            begin
                // matching slot, else first free, else least recent
                if (scan_res.done)
                begin
                    tbl_cmd.save_en  = 1'b1;
                    tbl_cmd.hit      = scan_res.hit;
                    tbl_cmd.hit_rank = scan_res.hit_rank;
                    tbl_cmd.fresh    = !scan_res.hit && scan_res.free;
                    if (scan_res.hit)
                    begin
                        tbl_cmd.idx = scan_res.hit_idx;
                    end
                    else if (scan_res.free)
                    begin
                        tbl_cmd.idx = scan_res.free_idx;
                    end
                    else
                    begin
                        tbl_cmd.idx = scan_res.lru_idx;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_DRAIN_SCAN:
            begin
                // load the result word and free the drained slot, if any
                if (scan_res.done)
                begin
                    out_valid_next = 1'b1;
                    present_next   = scan_res.head;
                    last_next      = (drain_k_reg ==
                                      lts_pkg::DRAIN_W'(lts_pkg::DRAIN_COUNT - 1));
                    if (scan_res.head)
                    begin
                        out_tag_next     = scan_res.head_tag;
                        out_pl_next      = pl_data;
                        tbl_cmd.drain_en = 1'b1;
                        tbl_cmd.idx      = scan_res.head_idx;
                    end
                    else
                    begin
                        out_tag_next = '0;
                        out_pl_next  = '0;
                    end
                    state_next = ST_DRAIN_OUT;
                end
            end

            ST_DRAIN_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        drain_k_next = drain_k_reg + lts_pkg::DRAIN_W'(1);
                        scan_start   = 1'b1;
                        state_next   = ST_DRAIN_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            receiver_id_reg <= '0;
            item_tag_reg    <= '0;
            item_pl_reg     <= '0;
            drain_k_reg     <= '0;
            out_valid_reg   <= 1'b0;
            present_reg     <= 1'b0;
            last_reg        <= 1'b0;
            out_tag_reg     <= '0;
            out_pl_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            receiver_id_reg <= receiver_id_next;
            item_tag_reg    <= item_tag_next;
            item_pl_reg     <= item_pl_next;
            drain_k_reg     <= drain_k_next;
            out_valid_reg   <= out_valid_next;
            present_reg     <= present_next;
            last_reg        <= last_next;
            out_tag_reg     <= out_tag_next;
            out_pl_reg      <= out_pl_next;
        end
    end

    // ports
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign present         = present_reg;
    assign receiver_out    = out_pl_reg.receiver;
    assign tag_id_out      = out_tag_reg;
    assign battery_out     = out_pl_reg.battery;
    assign signal_out      = $signed(out_pl_reg.rssi);
    assign sequence_out    = out_pl_reg.seq_num;
    assign temperature_out = $signed(out_pl_reg.temperature);
    assign last_of_run     = last_reg;

`include "lru_tag_store_top_assert.svh"

    `LTS_ASSERT_NEXT(a_drain_word_shown, (state_reg == ST_DRAIN_SCAN) && scan_res.done, out_valid_reg, "drain search ended without a result word")
    `LTS_ASSERT_NEXT(a_run_ends_idle, out_valid_reg && out_ready && last_reg, in_ready, "not ready after last word of a drain run")
    `LTS_ASSERT_IMPL(a_done_in_scan, scan_res.done, (state_reg == ST_SAVE_SCAN) || (state_reg == ST_DRAIN_SCAN), "slot search finished outside a search state")

endmodule

@@ test/tb_lru_tag_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_tag_store_top
// Self-checking bench for the recency-ordered tag report store. Save and
// drain words are pushed through the input handshake while a local model
// of the table (hit, free slot, eviction, recency ranks) predicts every
// drain result. Random idling on both sides, one long output hold-off and
// several receiver id settings are covered.
// ----------------------------------------------------------------------------
module tb_lru_tag_store_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int POOL_SIZE     = 14;

    // one input word as offered to the block
    typedef struct packed {
        logic        op;
        logic [31:0] tag;
        logic [7:0]  battery;
        logic [7:0]  rssi;
        logic [31:0] seq_num;
        logic [7:0]  temperature;
    } tag_word_t;

    // one drain result word
    typedef struct packed {
        logic        present;
        logic [31:0] receiver;
        logic [31:0] tag;
        logic [7:0]  battery;
        logic [7:0]  rssi;
        logic [31:0] seq_num;
        logic [7:0]  temperature;
        logic        last;
    } report_t;

    // one table slot of the local model
    typedef struct packed {
        logic [31:0]                tag;
        logic [31:0]                receiver;
        logic [7:0]                 battery;
        logic [7:0]                 rssi;
        logic [31:0]                seq_num;
        logic [7:0]                 temperature;
        logic [lts_pkg::RANK_W-1:0] rank;
    } slot_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [31:0]        cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = lts_pkg::FUNC_SAVE;
    logic [31:0]        tag_id_in = '0;
    logic [7:0]         battery_in = '0;
    logic signed [7:0]  signal_in = '0;
    logic [31:0]        sequence_in = '0;
    logic signed [7:0]  temperature_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               present;
    logic [31:0]        receiver_out;
    logic [31:0]        tag_id_out;
    logic [7:0]         battery_out;
    logic signed [7:0]  signal_out;
    logic [31:0]        sequence_out;
    logic signed [7:0]  temperature_out;
    logic               last_of_run;

    // local model state
    slot_t                     tag_table [lts_pkg::SLOTS];
    logic [lts_pkg::CNT_W-1:0] occupied;
    logic [31:0]               receiver_reg;
    report_t                   pending_reports [$];

    // run control and bookkeeping
    bit                 calm = 1'b0;
    int                 rx_hold = 0;
    int                 cycle_count = 0;
    int                 mismatches = 0;
    int                 saves_sent = 0;
    int                 drains_sent = 0;
    int                 reports_checked = 0;
    int                 id_settings = 1;

    lru_tag_store_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .tag_id_in       (tag_id_in),
        .battery_in      (battery_in),
        .signal_in       (signal_in),
        .sequence_in     (sequence_in),
        .temperature_in  (temperature_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .present         (present),
        .receiver_out    (receiver_out),
        .tag_id_out      (tag_id_out),
        .battery_out     (battery_out),
        .signal_out      (signal_out),
        .sequence_out    (sequence_out),
        .temperature_out (temperature_out),
        .last_of_run     (last_of_run)
    );

    // clock
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_lru_tag_store_top: done, errors");
            $finish;
        end
    end

    // result side ready: long hold-off on request, else random idling
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 27);
    end

    // model: clear the whole table
    function automatic void clear_table();
        for (int s = 0; s < lts_pkg::SLOTS; s++)
            tag_table[s] = '0;
        occupied = '0;
        receiver_reg = '0;
    endfunction

    // model: save one report (hit, else lowest free, else least recent)
    function automatic void store_report(tag_word_t w);
        int   pick;
        bit   fresh;
        logic [lts_pkg::RANK_W-1:0] old_rank;
        pick = lts_pkg::SLOTS;
        fresh = 1'b0;
        if (w.tag == '0)
            return;
        for (int s = 0; s < lts_pkg::SLOTS; s++)
            if (pick == lts_pkg::SLOTS && tag_table[s].tag == w.tag)
                pick = s;
        for (int s = 0; s < lts_pkg::SLOTS; s++)
            if (pick == lts_pkg::SLOTS && tag_table[s].tag == '0)
            begin
                pick = s;
                fresh = 1'b1;
            end
        for (int s = 0; s < lts_pkg::SLOTS; s++)
            if (pick == lts_pkg::SLOTS && tag_table[s].rank + 1 == occupied)
                pick = s;
        if (pick == lts_pkg::SLOTS)
            pick = 0;
        // age the others
        if (fresh)
        begin
            for (int s = 0; s < lts_pkg::SLOTS; s++)
                if (tag_table[s].tag != '0)
                    tag_table[s].rank++;
            occupied++;
        end
        else
        begin
            old_rank = tag_table[pick].rank;
            for (int s = 0; s < lts_pkg::SLOTS; s++)
                if (tag_table[s].tag != '0 && tag_table[s].rank < old_rank)
                    tag_table[s].rank++;
        end
        tag_table[pick].tag         = w.tag;
        tag_table[pick].receiver    = receiver_reg;
        tag_table[pick].battery     = w.battery;
        tag_table[pick].rssi        = w.rssi;
        tag_table[pick].seq_num     = w.seq_num;
        tag_table[pick].temperature = w.temperature;
        tag_table[pick].rank        = '0;
    endfunction

    // model: one drain run, most recent first, filler once empty
    function automatic void drain_reports();
        report_t r;
        int      head;
        for (int k = 0; k < lts_pkg::DRAIN_COUNT; k++)
        begin
            r = '0;
            head = lts_pkg::SLOTS;
            if (occupied != '0)
                for (int s = 0; s < lts_pkg::SLOTS; s++)
                    if (head == lts_pkg::SLOTS && tag_table[s].tag != '0 &&
                        tag_table[s].rank == '0)
                        head = s;
            if (head != lts_pkg::SLOTS)
            begin
                r.present     = 1'b1;
                r.receiver    = tag_table[head].receiver;
                r.tag         = tag_table[head].tag;
                r.battery     = tag_table[head].battery;
                r.rssi        = tag_table[head].rssi;
                r.seq_num     = tag_table[head].seq_num;
                r.temperature = tag_table[head].temperature;
                tag_table[head] = '0;
                for (int s = 0; s < lts_pkg::SLOTS; s++)
                    if (tag_table[s].tag != '0 && tag_table[s].rank != '0)
                        tag_table[s].rank--;
                occupied--;
            end
            r.last = (k == lts_pkg::DRAIN_COUNT - 1);
            pending_reports.push_back(r);
        end
    endfunction

    // send one word; returns at the accepting edge with valid still high
    task automatic send_word(input tag_word_t w);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= w.op;
        tag_id_in      <= w.tag;
        battery_in     <= w.battery;
        signal_in      <= w.rssi;
        sequence_in    <= w.seq_num;
        temperature_in <= w.temperature;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (w.op == lts_pkg::FUNC_DRAIN)
        begin
            drains_sent++;
            drain_reports();
        end
        else
        begin
            saves_sent++;
            store_report(w);
        end
    endtask

    // stop offering, let every expected word arrive, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver id register write, block idle
    task automatic write_receiver_id(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        receiver_reg = value;
    endtask

    function automatic tag_word_t make_word(logic op, logic [31:0] tag, logic [7:0] battery,
                                            logic [7:0] rssi, logic [31:0] seq_num,
                                            logic [7:0] temperature);
        tag_word_t w;
        w.op = op;
        w.tag = tag;
        w.battery = battery;
        w.rssi = rssi;
        w.seq_num = seq_num;
        w.temperature = temperature;
        return w;
    endfunction

    function automatic tag_word_t random_word(logic op, logic [31:0] tag);
        return make_word(op, tag, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         $urandom, 8'($urandom_range(255)));
    endfunction

    // compare one field of a result word
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result word: tag_id_out %0h", tag_id_out);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("present", want.present, present);
                check_field("receiver_out", want.receiver, receiver_out);
                check_field("tag_id_out", want.tag, tag_id_out);
                check_field("battery_out", want.battery, battery_out);
                check_field("signal_out", want.rssi, $unsigned(signal_out));
                check_field("sequence_out", want.seq_num, sequence_out);
                check_field("temperature_out", want.temperature,
                            $unsigned(temperature_out));
                check_field("last_of_run", want.last, last_of_run);
            end
        end
    end

    // drain straight after reset: all filler, reset receiver id
    task automatic test_drain_empty();
        send_word(random_word(lts_pkg::FUNC_DRAIN, $urandom));
        wait_idle();
    endtask

    // field extremes, zero tag dropped, partial drain with filler
    task automatic test_field_extremes();
        write_receiver_id(32'hFFFF_FFFF);
        id_settings++;
        send_word(make_word(lts_pkg::FUNC_SAVE, 32'hFFFF_FFFF, 8'hFF, 8'h80, 32'hFFFF_FFFF,
                            8'h7F));
        send_word(make_word(lts_pkg::FUNC_SAVE, 32'h0000_0001, 8'h00, 8'h7F, 32'h0000_0000,
                            8'h80));
        send_word(make_word(lts_pkg::FUNC_SAVE, 32'h0000_0000, 8'hAA, 8'h55, 32'h1234_5678,
                            8'h01));
        send_word(make_word(lts_pkg::FUNC_DRAIN, 32'h0, 8'h0, 8'h0, 32'h0, 8'h0));
        wait_idle();
    endtask

    // re-saving a known tag overwrites it and moves it to the front
    task automatic test_update_hit();
        write_receiver_id(32'h0);
        id_settings++;
        send_word(random_word(lts_pkg::FUNC_SAVE, 32'h0000_00A1));
        send_word(random_word(lts_pkg::FUNC_SAVE, 32'h0000_00B2));
        send_word(random_word(lts_pkg::FUNC_SAVE, 32'h0000_00A1));
        send_word(random_word(lts_pkg::FUNC_DRAIN, $urandom));
        wait_idle();
    endtask

    // fill the table, refresh the oldest, then evict the least recent
    task automatic test_eviction();
        for (int t = 1; t <= lts_pkg::SLOTS; t++)
            send_word(random_word(lts_pkg::FUNC_SAVE, t));
        send_word(random_word(lts_pkg::FUNC_SAVE, 32'd1));
        send_word(random_word(lts_pkg::FUNC_SAVE, 32'd11));
        for (int d = 0; d < 3; d++)
            send_word(random_word(lts_pkg::FUNC_DRAIN, $urandom));
        wait_idle();
    endtask

    // output held off while saves and drains keep coming
    task automatic test_output_backpressure();
        calm = 1'b1;
        rx_hold = 300;
        for (int t = 0; t < 10; t++)
            send_word(random_word(lts_pkg::FUNC_SAVE, $urandom_range(20, 1)));
        for (int d = 0; d < 6; d++)
            send_word(random_word(lts_pkg::FUNC_DRAIN, $urandom));
        wait_idle();
        calm = 1'b0;
    endtask

    // bursts of saves over a small tag pool, then drain runs
    task automatic test_random_traffic(input int n_items, input logic [31:0] rx_id,
                                       input bit no_idle);
        logic [31:0] pool [POOL_SIZE];
        logic [31:0] tag;
        int          sent;
        int          n_saves;
        int          n_drains;
        int          r;
        write_receiver_id(rx_id);
        id_settings++;
        calm = no_idle;
        pool[0] = 32'hFFFF_FFFF;
        for (int i = 1; i < POOL_SIZE; i++)
            pool[i] = (i < 6) ? i : ($urandom | 32'h1);
        sent = 0;
        while (sent < n_items)
        begin
            n_saves = $urandom_range(16, 1);
            for (int i = 0; i < n_saves; i++)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    tag = '0;
                else if (r < 10)
                    tag = $urandom;
                else
                    tag = pool[$urandom_range(POOL_SIZE - 1)];
                send_word(random_word(lts_pkg::FUNC_SAVE, tag));
                if (tag != '0)
                    sent++;
            end
            n_drains = $urandom_range(3, 0);
            for (int d = 0; d < n_drains; d++)
            begin
                send_word(random_word(lts_pkg::FUNC_DRAIN, $urandom));
                sent++;
            end
        end
        wait_idle();
        calm = 1'b0;
    endtask

    // test sequence
    initial
    begin
        clear_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_drain_empty();
        test_field_extremes();
        test_update_hit();
        test_eviction();
        test_random_traffic(75, $urandom, 1'b0);
        test_random_traffic(75, 32'h0000_0001, 1'b1);
        test_output_backpressure();
        test_random_traffic(75, 32'h8000_0000, 1'b0);
        test_random_traffic(75, 32'hFFFF_FFFF, 1'b0);

        $display("covered %0d saves and %0d drains over %0d receiver id settings,",
                 saves_sent, drains_sent, id_settings);
        $display("hits, evictions, zero tags, filler and a long output stall; %0d words checked",
                 reports_checked);
        if (mismatches == 0)
            $display("tb_lru_tag_store_top: done, clean");
        else
            $display("tb_lru_tag_store_top: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lts_pkg.sv
rtl/lts_table.sv
rtl/lts_scan.sv
rtl/lru_tag_store_top.sv
test/tb_lru_tag_store_top.sv
